[sv/tspf_pkg.sv]
`timescale 1ns / 1ps
// Package: shared constants, codes and the output word type of the TS PID filter.
package tspf_pkg;

  localparam int PACKET_BYTES_DEF = 188;
  localparam int MAP_DEPTH_DEF    = 8192;

  localparam int POS_W   = 8;
  localparam int PID_W   = 13;
  localparam int START_W = 9;
  localparam int BYTE_W  = 8;

  localparam logic [BYTE_W-1:0]  SYNC_BYTE         = 8'h47;
  localparam logic [START_W-1:0] TS_BODY           = 9'd188;
  localparam logic [START_W-1:0] PAYLOAD_START_RST = 9'd4;
  localparam logic [START_W-1:0] ADAPT_HDR_BYTES   = 9'd5;

  localparam logic CMD_TS_BYTE = 1'b0;
  localparam logic CMD_SET_PID = 1'b1;

  localparam logic [POS_W-1:0] POS_SYNC      = 8'd0;
  localparam logic [POS_W-1:0] POS_PID_HI    = 8'd1;
  localparam logic [POS_W-1:0] POS_PID_LO    = 8'd2;
  localparam logic [POS_W-1:0] POS_AFC       = 8'd3;
  localparam logic [POS_W-1:0] POS_ADAPT_LEN = 8'd4;

  typedef enum logic [1:0] {
    AFC_RESERVED      = 2'd0,
    AFC_PAYLOAD       = 2'd1,
    AFC_ADAPT_ONLY    = 2'd2,
    AFC_ADAPT_PAYLOAD = 2'd3
  } afc_e;

  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic [PID_W-1:0]  packet_pid;
    logic              first_of_payload;
    logic              last_of_packet;
  } tspf_word_t;

endpackage

[sv/ts_pid_filter_payload_extract.sv]
`timescale 1ns / 1ps
// Top level: TS packet parser with PID filter bitmap in RAM and payload word output.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------------------
//   in      | input     | in_valid_i/in_stall_o | cmd_i, ts_byte_i, filter_pid_i
//   out     | output    | out_valid_o/out_stall_i | payload_byte_o, packet_pid_o,
//           |           |                      | first_of_payload_o, last_of_packet_o
//
// One input word per cycle while in_stall_o is low; payload words are registered at the output.
// The PID bitmap is read at packet byte 2; its answer is folded into the drop flag next cycle.
// After reset the bitmap is swept to zero, address by address, with in_stall_o held high.
// One skid entry absorbs a word while out_stall_i is high; in_stall_o also rises when it is full.
module ts_pid_filter_payload_extract #(
  parameter int PACKET_BYTES = tspf_pkg::PACKET_BYTES_DEF,
  parameter int MAP_DEPTH    = tspf_pkg::MAP_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         cmd_i,
  input  logic [tspf_pkg::BYTE_W-1:0]  ts_byte_i,
  input  logic [tspf_pkg::PID_W-1:0]   filter_pid_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [tspf_pkg::BYTE_W-1:0]  payload_byte_o,
  output logic [tspf_pkg::PID_W-1:0]   packet_pid_o,
  output logic                         first_of_payload_o,
  output logic                         last_of_packet_o
);
  import tspf_pkg::*;

  localparam int PidAw = $clog2(MAP_DEPTH);
  localparam logic [PID_W:0]   PidLim  = (PID_W + 1)'(MAP_DEPTH);
  localparam logic [PidAw-1:0] ClrLast = PidAw'(MAP_DEPTH - 1);
  localparam logic [POS_W-1:0] PosLast = POS_W'(PACKET_BYTES - 1);
  localparam logic [POS_W-1:0] BodyLast = POS_W'(TS_BODY - 9'd1);

  logic             clearing_q;
  logic [PidAw-1:0] clr_addr_q;

  logic [POS_W-1:0]   pos_q, pos_d;
  logic [PID_W-1:0]   pid_q, pid_d;
  afc_e               afc_q, afc_d;
  logic [START_W-1:0] start_q, start_d;
  logic               dropped_q, dropped_d;
  logic               pid_chk_q, pid_chk_d;
  logic               pid_rng_q, pid_rng_d;

  logic             in_acc, byte_acc, set_acc, ob_busy;
  logic             map_rdata, pid_ok, drop_eff, rd_en;
  logic [PID_W-1:0] pid_lo_w;
  logic             res_v;
  tspf_word_t       res, out_word;

  assign in_stall_o = clearing_q | ob_busy;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign byte_acc   = in_acc & (cmd_i == CMD_TS_BYTE);
  assign set_acc    = in_acc & (cmd_i == CMD_SET_PID) & (pos_q == POS_SYNC) &
                      ({1'b0, filter_pid_i} < PidLim);

  assign pid_lo_w = {pid_q[PID_W-1:BYTE_W], ts_byte_i};
  assign pid_ok   = pid_rng_q & map_rdata;
  assign drop_eff = dropped_q | (pid_chk_q & ~pid_ok);

  always_comb begin
    pid_d     = pid_q;
    afc_d     = afc_q;
    start_d   = start_q;
    dropped_d = drop_eff;
    pid_chk_d = 1'b0;
    pid_rng_d = pid_rng_q;
    rd_en     = 1'b0;
    pos_d     = pos_q;
    if (byte_acc) begin
      pos_d = (pos_q == PosLast) ? '0 : pos_q + POS_W'(1);
      unique case (pos_q)
        POS_SYNC: begin
          dropped_d = (ts_byte_i != SYNC_BYTE);
          start_d   = PAYLOAD_START_RST;
          afc_d     = AFC_RESERVED;
        end
        POS_PID_HI: begin
          pid_d = {ts_byte_i[4:0], pid_q[BYTE_W-1:0]};
        end
        POS_PID_LO: begin
          pid_d     = pid_lo_w;
          rd_en     = 1'b1;
          pid_chk_d = 1'b1;
          pid_rng_d = ({1'b0, pid_lo_w} < PidLim);
        end
        POS_AFC: begin
          afc_d = afc_e'(ts_byte_i[5:4]);
          if (afc_d == AFC_RESERVED || afc_d == AFC_ADAPT_ONLY) begin
            dropped_d = 1'b1;
          end
        end
        POS_ADAPT_LEN: begin
          if (afc_q == AFC_ADAPT_PAYLOAD) begin
            start_d = ADAPT_HDR_BYTES + {1'b0, ts_byte_i};
          end
          if (start_d >= TS_BODY) begin
            dropped_d = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign res_v = byte_acc & ~dropped_d & ({1'b0, pos_q} >= start_d) &
                 ({1'b0, pos_q} < TS_BODY);
  assign res.payload_byte     = ts_byte_i;
  assign res.packet_pid       = pid_d;
  assign res.first_of_payload = ({1'b0, pos_q} == start_d);
  assign res.last_of_packet   = (pos_q == BodyLast);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
      pos_q      <= '0;
      pid_q      <= '0;
      afc_q      <= AFC_RESERVED;
      start_q    <= PAYLOAD_START_RST;
      dropped_q  <= 1'b0;
      pid_chk_q  <= 1'b0;
      pid_rng_q  <= 1'b0;
    end else begin
      if (clearing_q) begin
        clr_addr_q <= clr_addr_q + PidAw'(1);
        if (clr_addr_q == ClrLast) begin
          clearing_q <= 1'b0;
        end
      end
      pos_q     <= pos_d;
      pid_q     <= pid_d;
      afc_q     <= afc_d;
      start_q   <= start_d;
      dropped_q <= dropped_d;
      pid_chk_q <= pid_chk_d;
      pid_rng_q <= pid_rng_d;
    end
  end

  tspf_ram #(
    .Width (1),
    .Depth (MAP_DEPTH)
  ) u_pid_map (
    .clk_i   (clk_i),
    .we_i    (clearing_q | set_acc),
    .waddr_i (clearing_q ? clr_addr_q : filter_pid_i[PidAw-1:0]),
    .wdata_i (~clearing_q),
    .re_i    (rd_en),
    .raddr_i (pid_lo_w[PidAw-1:0]),
    .rdata_o (map_rdata)
  );

  tspf_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_v),
    .res_i       (res),
    .busy_o      (ob_busy),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word),
    .out_stall_i (out_stall_i)
  );

  assign payload_byte_o     = out_word.payload_byte;
  assign packet_pid_o       = out_word.packet_pid;
  assign first_of_payload_o = out_word.first_of_payload;
  assign last_of_packet_o   = out_word.last_of_packet;

  a_no_out_while_clearing : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> !out_valid_o)
    else $error("output word during bitmap clear");

  a_pid_check_after_byte2 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pid_chk_q |-> $past(byte_acc && pos_q == POS_PID_LO))
    else $error("PID check without PID low byte");

  a_result_in_body : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_v |-> (pos_q >= POS_ADAPT_LEN && pos_q <= BodyLast))
    else $error("payload word outside packet body");

  a_no_byte_in_pid_check : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pid_chk_q |-> pos_q == POS_AFC)
    else $error("PID check not aligned to AFC byte");

endmodule

[sv/tspf_ram.sv]
`timescale 1ns / 1ps
// Generic single-clock RAM: one write port, one read port with registered read data.
module tspf_ram #(
  parameter int Width = 1,
  parameter int Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/tspf_out_buf.sv]
`timescale 1ns / 1ps
// Output register with one skid entry for the payload word channel.
module tspf_out_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                res_valid_i,
  input  tspf_pkg::tspf_word_t res_i,
  output logic                busy_o,
  output logic                out_valid_o,
  output tspf_pkg::tspf_word_t out_word_o,
  input  logic                out_stall_i
);
  import tspf_pkg::*;

  logic       out_v_q, out_v_d;
  logic       skid_v_q, skid_v_d;
  tspf_word_t out_q, out_d;
  tspf_word_t skid_q, skid_d;

  always_comb begin
    out_v_d  = out_v_q;
    out_d    = out_q;
    skid_v_d = skid_v_q;
    skid_d   = skid_q;
    if (!out_v_q || !out_stall_i) begin
      if (skid_v_q) begin
        out_v_d  = 1'b1;
        out_d    = skid_q;
        skid_v_d = 1'b0;
      end else begin
        out_v_d = res_valid_i;
        out_d   = res_i;
      end
    end else if (res_valid_i) begin
      skid_v_d = 1'b1;
      skid_d   = res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign busy_o      = skid_v_q;
  assign out_valid_o = out_v_q;
  assign out_word_o  = out_q;

endmodule
